@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/brr_pkg.sv @@
// Package: types, constants and CRC function of the bond record receiver.
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

  localparam int RECORD_BYTES = 32;
  localparam int COUNT_W      = $clog2(RECORD_BYTES);

  localparam logic [COUNT_W-1:0] CRC_SPAN = COUNT_W'(28);
  localparam logic [COUNT_W-1:0] LAST_IDX = COUNT_W'(RECORD_BYTES - 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  // "APB1"
  localparam logic [7:0] MAGIC_0 = 8'h41;
  localparam logic [7:0] MAGIC_1 = 8'h50;
  localparam logic [7:0] MAGIC_2 = 8'h42;
  localparam logic [7:0] MAGIC_3 = 8'h31;

  typedef enum logic [1:0] {
    KIND_ARM  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [63:0] bond_id;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } brr_result_t;

  typedef struct packed {
    logic               armed;
    logic               expired;
    logic [COUNT_W-1:0] byte_count;
  } brr_sess_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/bond_record_receiver_top.sv @@
// Bond record receiver: framed 32-byte record with CRC-32 check, top level.
//
// Input channel (in_valid_i / in_stall_o): kind_i is arm, data byte or tick.
// Arm opens a session; 32 data bytes form a record; ticks count toward the
// timeout set by cfg_wdata_i, written with cfg_we_i while the block is idle
// (a rule for the user; the block itself does not enforce it). Output channel
// (out_valid_o / out_stall_i): one transaction per finished record (valid or
// invalid) or for the first data byte that arrives after the timeout.
// Each input transaction passes the input register, then the result register.
// Throughput: one input transaction per cycle unless the receiver stalls; the
// state update of one item is a combinational step between the input register
// and the result register. When the receiver stalls, the result register holds,
// the input register fills behind it and in_stall_o then rises; nothing is
// dropped. Reset: no session open, timeout 5000 ticks, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bond_record_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [63:0]      bond_id_o,
  output logic [63:0]      key_upper_o,
  output logic [63:0]      key_lower_o
);

  logic                 advance;
  logic                 item_valid;
  logic [1:0]           item_kind;
  logic [7:0]           item_byte;
  logic                 res_valid;
  brr_pkg::brr_result_t result;
  brr_pkg::brr_result_t out_result;
  brr_pkg::brr_sess_t   sess;
  logic                 sess_open;
  logic                 count_busy;
  logic                 res_invalid;
  logic                 fields_nonzero;

  brr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .item_valid_o (item_valid),
    .kind_o       (item_kind),
    .data_byte_o  (item_byte)
  );

  brr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .kind_i       (item_kind),
    .data_byte_i  (item_byte),
    .res_valid_o  (res_valid),
    .result_o     (result),
    .sess_o       (sess)
  );

  brr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign status_o    = out_result.status;
  assign bond_id_o   = out_result.bond_id;
  assign key_upper_o = out_result.key_upper;
  assign key_lower_o = out_result.key_lower;

  assign sess_open      = sess.armed && !sess.expired;
  assign count_busy     = (sess.byte_count != '0);
  assign res_invalid    = out_valid_o && (status_o != brr_pkg::STATUS_VALID);
  assign fields_nonzero = (bond_id_o != '0) || (key_upper_o != '0) || (key_lower_o != '0);

  `ASSERT_PROP(a_expired_needs_armed, clk_i, rst_ni, sess.expired |-> sess.armed)
  `ASSERT_PROP(a_count_needs_open, clk_i, rst_ni, count_busy |-> sess_open)
  `ASSERT_NEVER(a_fields_zero_unless_valid, clk_i, rst_ni, res_invalid && fields_nonzero)

endmodule

`default_nettype wire

@@ sv/brr_in_reg.sv @@
// Input register stage with stall back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module brr_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       advance_i,
  output logic            in_stall_o,
  output logic            item_valid_o,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;

  assign in_stall_o   = valid_q && !advance_i;
  assign item_valid_o = valid_q && advance_i;
  assign kind_o       = kind_q;
  assign data_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_i;
      byte_q <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/brr_core.sv @@
// Session state, record store, CRC and record check.
`timescale 1ns / 1ps
`default_nettype none

module brr_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               item_valid_i,
  input  wire logic [1:0]         kind_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    res_valid_o,
  output brr_pkg::brr_result_t    result_o,
  output brr_pkg::brr_sess_t      sess_o
);

  logic [15:0] timeout_q;
  logic [7:0]  store_q [brr_pkg::RECORD_BYTES];

  logic                        armed_q, armed_d;
  logic                        expired_q, expired_d;
  logic [15:0]                 elapsed_q, elapsed_d;
  logic [brr_pkg::COUNT_W-1:0] count_q, count_d;
  logic [31:0]                 crc_q, crc_d;
  logic                        store_we;

  logic [15:0] elapsed_inc;
  logic [31:0] stored_crc;
  logic [7:0]  id_or, key_or;
  logic        magic_ok, crc_ok;
  logic [63:0] id_word, key_hi_word, key_lo_word;

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign stored_crc  = {data_byte_i, store_q[30], store_q[29], store_q[28]};
  assign magic_ok    = (store_q[0] == brr_pkg::MAGIC_0) && (store_q[1] == brr_pkg::MAGIC_1) &&
                       (store_q[2] == brr_pkg::MAGIC_2) && (store_q[3] == brr_pkg::MAGIC_3);
  assign crc_ok      = (stored_crc == ~crc_q);

  always_comb begin
    id_or       = '0;
    key_or      = '0;
    id_word     = '0;
    key_hi_word = '0;
    key_lo_word = '0;
    for (int i = 0; i < 8; i++) begin
      id_or  = id_or | store_q[4 + i];
      key_or = key_or | store_q[12 + i] | store_q[20 + i];
      id_word[63 - 8*i -: 8]     = store_q[4 + i];
      key_hi_word[63 - 8*i -: 8] = store_q[12 + i];
      key_lo_word[63 - 8*i -: 8] = store_q[20 + i];
    end
  end

  always_comb begin
    armed_d     = armed_q;
    expired_d   = expired_q;
    elapsed_d   = elapsed_q;
    count_d     = count_q;
    crc_d       = crc_q;
    store_we    = 1'b0;
    res_valid_o = 1'b0;
    result_o    = '{status: brr_pkg::STATUS_INVALID, default: '0};
    if (item_valid_i) begin
      case (brr_pkg::kind_e'(kind_i))
        brr_pkg::KIND_ARM: begin
          armed_d   = 1'b1;
          expired_d = 1'b0;
          elapsed_d = '0;
          count_d   = '0;
          crc_d     = brr_pkg::CRC_INIT;
        end
        brr_pkg::KIND_TICK: begin
          if (armed_q && !expired_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_q) begin
              expired_d = 1'b1;
              count_d   = '0;
              crc_d     = brr_pkg::CRC_INIT;
            end
          end
        end
        brr_pkg::KIND_DATA: begin
          if (armed_q) begin
            if (expired_q || (elapsed_q >= timeout_q)) begin
              res_valid_o     = 1'b1;
              result_o.status = brr_pkg::STATUS_TIMEOUT;
            end else begin
              store_we = 1'b1;
              if (count_q < brr_pkg::CRC_SPAN) begin
                crc_d = brr_pkg::crc32_byte(crc_q, data_byte_i);
              end
              if (count_q == brr_pkg::LAST_IDX) begin
                res_valid_o = 1'b1;
                if (magic_ok && crc_ok && (id_or != '0) && (key_or != '0)) begin
                  result_o.status    = brr_pkg::STATUS_VALID;
                  result_o.bond_id   = id_word;
                  result_o.key_upper = key_hi_word;
                  result_o.key_lower = key_lo_word;
                end
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            if (res_valid_o) begin
              armed_d   = 1'b0;
              expired_d = 1'b0;
              elapsed_d = '0;
              count_d   = '0;
              crc_d     = brr_pkg::CRC_INIT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= brr_pkg::TIMEOUT_RESET;
      armed_q   <= 1'b0;
      expired_q <= 1'b0;
      elapsed_q <= '0;
      count_q   <= '0;
      crc_q     <= brr_pkg::CRC_INIT;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      armed_q   <= armed_d;
      expired_q <= expired_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
    end
  end

  // Every byte is written in order after a clear, so the store needs no reset.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= data_byte_i;
    end
  end

  assign sess_o = '{armed: armed_q, expired: expired_q, byte_count: count_q};

endmodule

`default_nettype wire

@@ sv/brr_out_reg.sv @@
// Result register; when full, the receiver's stall holds it and, through advance_o, the input register.
`timescale 1ns / 1ps
`default_nettype none

module brr_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 res_valid_i,
  input  wire brr_pkg::brr_result_t result_i,
  input  wire logic                 out_stall_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  output brr_pkg::brr_result_t      result_o
);

  logic                 valid_q;
  brr_pkg::brr_result_t result_q;

  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_bond_record_receiver_top.sv @@
// Testbench for bond_record_receiver_top: record, CRC and timeout checks against a local model.
`timescale 1ns / 1ps

module tb_bond_record_receiver_top;

  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam int         CYCLE_LIMIT = 100_000;
  localparam int         DRAIN_WAIT  = 4;
  localparam int         RAND_ITEMS  = 700;

  typedef enum int {
    FRAME_GOOD,
    FRAME_ONES,
    FRAME_BAD_MAGIC,
    FRAME_BAD_CRC,
    FRAME_ZERO_ID,
    FRAME_ZERO_KEY,
    FRAME_NOISE
  } frame_e;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  kind = '0;
  logic [7:0]  data_byte = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [63:0] bond_id;
  logic [63:0] key_upper;
  logic [63:0] key_lower;

  // model state
  logic [15:0]          exp_timeout = brr_pkg::TIMEOUT_RESET;
  logic [7:0]           rec_bytes [brr_pkg::RECORD_BYTES];
  int                   rec_count;
  logic [31:0]          rec_crc;
  bit                   sess_armed;
  bit                   sess_expired;
  logic [15:0]          sess_ticks;
  brr_pkg::brr_result_t expected_q [$];

  logic [7:0]           frame_buf [brr_pkg::RECORD_BYTES];
  brr_pkg::brr_result_t head;
  bit                   gaps_on = 1'b1;
  int                   holdoff_left = 0;
  int                   items_sent = 0;
  int                   results_checked = 0;
  int                   failures = 0;
  int                   cycle_count = 0;

  bond_record_receiver_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .bond_id_o   (bond_id),
    .key_upper_o (key_upper),
    .key_lower_o (key_lower)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // receiver side: long hold-off when requested, else random stalls while gaps_on is set
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (gaps_on) begin
      out_stall <= ($urandom_range(99) < 24);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: status %0d", status);
        failures++;
      end else begin
        head = expected_q.pop_front();
        results_checked++;
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          failures++;
        end
        if (bond_id !== head.bond_id) begin
          $error("bond_id: expected %h, got %h", head.bond_id, bond_id);
          failures++;
        end
        if (key_upper !== head.key_upper) begin
          $error("key_upper: expected %h, got %h", head.key_upper, key_upper);
          failures++;
        end
        if (key_lower !== head.key_lower) begin
          $error("key_lower: expected %h, got %h", head.key_lower, key_lower);
          failures++;
        end
      end
    end
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] s;
    s = c;
    for (int i = 0; i < 8; i++) begin
      s = (s >> 1) ^ ((s[0] ^ b[i]) ? brr_pkg::CRC_POLY : 32'd0);
    end
    return s;
  endfunction

  function automatic logic [63:0] rec_word(input int start);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w = {w[55:0], rec_bytes[start + i]};
    end
    return w;
  endfunction

  task automatic clear_record();
    foreach (rec_bytes[i]) rec_bytes[i] = 8'd0;
    rec_count = 0;
    rec_crc = brr_pkg::CRC_INIT;
  endtask

  task automatic close_session();
    clear_record();
    sess_armed = 1'b0;
    sess_expired = 1'b0;
    sess_ticks = '0;
  endtask

  task automatic judge_record();
    brr_pkg::brr_result_t r;
    logic [7:0]           id_or;
    logic [7:0]           key_or;
    logic [31:0]          crc_field;
    r = '0;
    id_or = '0;
    key_or = '0;
    for (int i = 4; i < 12; i++) id_or |= rec_bytes[i];
    for (int i = 12; i < 28; i++) key_or |= rec_bytes[i];
    crc_field = {rec_bytes[31], rec_bytes[30], rec_bytes[29], rec_bytes[28]};
    if (rec_bytes[0] == brr_pkg::MAGIC_0 && rec_bytes[1] == brr_pkg::MAGIC_1 &&
        rec_bytes[2] == brr_pkg::MAGIC_2 && rec_bytes[3] == brr_pkg::MAGIC_3 &&
        crc_field == ~rec_crc && id_or != 0 && key_or != 0) begin
      r.status = brr_pkg::STATUS_VALID;
      r.bond_id = rec_word(4);
      r.key_upper = rec_word(12);
      r.key_lower = rec_word(20);
    end else begin
      r.status = brr_pkg::STATUS_INVALID;
    end
    expected_q.push_back(r);
  endtask

  task automatic predict_item(input logic [1:0] k, input logic [7:0] b);
    brr_pkg::brr_result_t r;
    r = '0;
    case (k)
      brr_pkg::KIND_ARM: begin
        clear_record();
        sess_armed = 1'b1;
        sess_expired = 1'b0;
        sess_ticks = '0;
      end
      brr_pkg::KIND_TICK: begin
        if (sess_armed && !sess_expired) begin
          if (sess_ticks != 16'hFFFF) sess_ticks++;
          if (sess_ticks >= exp_timeout) begin
            sess_expired = 1'b1;
            clear_record();
          end
        end
      end
      brr_pkg::KIND_DATA: begin
        if (sess_armed) begin
          if (sess_expired || sess_ticks >= exp_timeout) begin
            r.status = brr_pkg::STATUS_TIMEOUT;
            expected_q.push_back(r);
            close_session();
          end else begin
            rec_bytes[rec_count] = b;
            if (rec_count < 28) rec_crc = crc_step(rec_crc, b);
            rec_count++;
            if (rec_count == brr_pkg::RECORD_BYTES) begin
              judge_record();
              close_session();
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] k, input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= k;
    data_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_item(k, b);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_wdata <= ticks;
    cfg_we <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    exp_timeout = ticks;
  endtask

  task automatic build_frame(input frame_e shape);
    logic [31:0] c;
    int          idx;
    frame_buf[0] = brr_pkg::MAGIC_0;
    frame_buf[1] = brr_pkg::MAGIC_1;
    frame_buf[2] = brr_pkg::MAGIC_2;
    frame_buf[3] = brr_pkg::MAGIC_3;
    for (int i = 4; i < 28; i++) frame_buf[i] = 8'($urandom);
    case (shape)
      FRAME_ONES: for (int i = 4; i < 28; i++) frame_buf[i] = 8'hFF;
      FRAME_ZERO_ID: for (int i = 4; i < 12; i++) frame_buf[i] = 8'h00;
      FRAME_ZERO_KEY: for (int i = 12; i < 28; i++) frame_buf[i] = 8'h00;
      FRAME_BAD_MAGIC: begin
        idx = $urandom_range(3);
        frame_buf[idx] = frame_buf[idx] ^ (8'd1 << $urandom_range(7));
      end
      FRAME_NOISE: for (int i = 0; i < 4; i++) frame_buf[i] = 8'($urandom);
      default: ;
    endcase
    c = brr_pkg::CRC_INIT;
    for (int i = 0; i < 28; i++) c = crc_step(c, frame_buf[i]);
    c = ~c;
    {frame_buf[31], frame_buf[30], frame_buf[29], frame_buf[28]} = c;
    if (shape == FRAME_BAD_CRC) begin
      idx = 28 + $urandom_range(3);
      frame_buf[idx] = frame_buf[idx] ^ (8'd1 << $urandom_range(7));
    end else if (shape == FRAME_NOISE) begin
      for (int i = 28; i < 32; i++) frame_buf[i] = 8'($urandom);
    end
  endtask

  // arm, then up to cut_at record bytes with ticks and reserved kinds mixed in
  task automatic send_session(input frame_e shape, input int tick_pct, input int cut_at);
    build_frame(shape);
    send_item(brr_pkg::KIND_ARM, 8'($urandom));
    for (int i = 0; i < brr_pkg::RECORD_BYTES; i++) begin
      if (i == cut_at) break;
      while ($urandom_range(99) < tick_pct) send_item(brr_pkg::KIND_TICK, 8'($urandom));
      if ($urandom_range(99) < 2) send_item(KIND_RSVD, 8'($urandom));
      send_item(brr_pkg::KIND_DATA, frame_buf[i]);
    end
  endtask

  task automatic test_no_session();
    send_item(brr_pkg::KIND_DATA, 8'h41);
    send_item(brr_pkg::KIND_TICK, 8'h00);
    send_item(KIND_RSVD, 8'hFF);
  endtask

  // many ticks under the reset timeout still give a valid record
  task automatic test_reset_timeout();
    build_frame(FRAME_GOOD);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    repeat (100) send_item(brr_pkg::KIND_TICK, 8'($urandom));
    for (int i = 0; i < brr_pkg::RECORD_BYTES; i++) begin
      send_item(brr_pkg::KIND_DATA, frame_buf[i]);
    end
  endtask

  task automatic test_record_checks();
    send_session(FRAME_GOOD, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_ONES, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_BAD_MAGIC, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_BAD_CRC, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_ZERO_ID, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_ZERO_KEY, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_NOISE, 0, brr_pkg::RECORD_BYTES);
    send_session(FRAME_GOOD, 0, 10);
    send_session(FRAME_GOOD, 0, brr_pkg::RECORD_BYTES);
  endtask

  task automatic test_timeout_cases();
    wait_idle();
    write_timeout(16'd1);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    send_item(brr_pkg::KIND_TICK, 8'h00);
    send_item(brr_pkg::KIND_TICK, 8'hFF);
    send_item(KIND_RSVD, 8'h5A);
    send_item(brr_pkg::KIND_DATA, 8'h00);
    send_item(brr_pkg::KIND_DATA, 8'hFF);
    wait_idle();
    write_timeout(16'd2);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    send_item(brr_pkg::KIND_TICK, 8'h00);
    send_item(brr_pkg::KIND_TICK, 8'h00);
    send_session(FRAME_GOOD, 0, brr_pkg::RECORD_BYTES);
    wait_idle();
    write_timeout(16'd0);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    send_item(brr_pkg::KIND_DATA, 8'h41);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    send_item(brr_pkg::KIND_TICK, 8'h00);
    send_item(brr_pkg::KIND_DATA, 8'h41);
    wait_idle();
    write_timeout(16'd10);
    send_item(brr_pkg::KIND_ARM, 8'h00);
    repeat (3) send_item(brr_pkg::KIND_TICK, 8'h00);
    build_frame(FRAME_GOOD);
    for (int i = 0; i < 5; i++) send_item(brr_pkg::KIND_DATA, frame_buf[i]);
    wait_idle();
    write_timeout(16'd2);
    send_item(brr_pkg::KIND_DATA, frame_buf[5]);
  endtask

  task automatic test_max_timeout();
    wait_idle();
    write_timeout(16'hFFFF);
    gaps_on = 1'b0;
    send_session(FRAME_GOOD, 50, brr_pkg::RECORD_BYTES);
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_timeout(16'd0);
    holdoff_left = 200;
    repeat (30) begin
      send_item(brr_pkg::KIND_ARM, 8'($urandom));
      send_item(brr_pkg::KIND_DATA, 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_sessions();
    int     target;
    int     sessions;
    int     pick;
    frame_e shape;
    target = items_sent + RAND_ITEMS;
    sessions = 0;
    while (items_sent < target) begin
      if (sessions % 8 == 0) begin
        wait_idle();
        case ($urandom_range(4))
          0: write_timeout(16'($urandom_range(1, 8)));
          1: write_timeout(16'($urandom_range(9, 64)));
          2: write_timeout(16'hFFFF);
          3: write_timeout(16'($urandom_range(65, 65535)));
          default: write_timeout(16'($urandom_range(0, 3)));
        endcase
      end
      gaps_on = !(sessions >= 12 && sessions < 20);
      pick = $urandom_range(99);
      if (pick < 85) begin
        shape = ($urandom_range(99) < 55) ? FRAME_GOOD :
                frame_e'($urandom_range(int'(FRAME_ONES), int'(FRAME_NOISE)));
        send_session(shape, $urandom_range(0, 12),
                     ($urandom_range(9) == 0) ? $urandom_range(1, brr_pkg::RECORD_BYTES - 1)
                                              : brr_pkg::RECORD_BYTES);
      end else begin
        repeat ($urandom_range(1, 5)) send_item(2'($urandom_range(3)), 8'($urandom));
      end
      sessions++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    close_session();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_no_session();
    test_reset_timeout();
    test_record_checks();
    test_timeout_cases();
    test_max_timeout();
    test_backpressure();
    test_random_sessions();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      failures++;
    end
    $display("run covered %0d input transactions and %0d checked results", items_sent,
             results_checked);
    $display("records good and flawed, timeouts at 0, 1, lowered, reset, max, random, hold-off");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/brr_pkg.sv
sv/brr_in_reg.sv
sv/brr_core.sv
sv/brr_out_reg.sv
sv/bond_record_receiver_top.sv
dv/tb_bond_record_receiver_top.sv
